// File: design/dfsw_pkg.sv
package dfsw_pkg;

  // vertex index width, fixed by the edge and result fields
  localparam int unsigned VW = 3;
  // scan limit never goes past eight vertices
  localparam int unsigned SCAN_MAX = 8;
  localparam int unsigned VCOUNT_W = 4;
  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 4'd8;
  localparam int unsigned OP_W = 2;
  localparam int unsigned PC_W = 3;
  localparam int unsigned DEF_MAX_VERTICES = 8;
  localparam int unsigned DEF_STACK_DEPTH = 16;

  typedef enum logic [OP_W-1:0] {
    OP_SET_EDGE = 2'd0,
    OP_CLEAR    = 2'd1,
    OP_WALK     = 2'd2,
    OP_NOP      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    VISIT_NONE  = 2'd0,
    VISIT_INIT  = 2'd1,
    VISIT_SET   = 2'd2,
    VISIT_CLEAR = 2'd3
  } visit_e;

  typedef enum logic [1:0] {
    COND_NEVER    = 2'd0,
    COND_NO_START = 2'd1,
    COND_SP_EMPTY = 2'd2,
    COND_NO_NBR   = 2'd3
  } cond_e;

  // datapath actions of one microcode step
  typedef struct packed {
    logic   push;
    logic   push_zero;
    logic   pop;
    logic   cur_from_stack;
    logic   cur_from_nbr;
    visit_e visit;
    logic   emit;
    logic   emit_last;
  } ctrl_t;

  typedef struct packed {
    cond_e           cond;
    logic [PC_W-1:0] jump;
    logic [PC_W-1:0] next;
    ctrl_t           ctrl;
  } uword_t;

  // datapath flags tested by the sequencer
  typedef struct packed {
    logic sp_empty;
    logic nbr_found;
    logic out_free;
  } stat_t;

endpackage

// File: design/dfsw_sequencer.sv
module dfsw_sequencer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  dfsw_pkg::stat_t stat_i,
  output dfsw_pkg::ctrl_t ctrl_o,
  output logic           idle_o
);
  import dfsw_pkg::*;

  localparam logic [PC_W-1:0] STEP_IDLE  = 3'd0;
  localparam logic [PC_W-1:0] STEP_INIT  = 3'd1;
  localparam logic [PC_W-1:0] STEP_POPRQ = 3'd2;
  localparam logic [PC_W-1:0] STEP_POPUS = 3'd3;
  localparam logic [PC_W-1:0] STEP_SCAN  = 3'd4;
  localparam logic [PC_W-1:0] STEP_PUSH  = 3'd5;
  localparam logic [PC_W-1:0] STEP_FLUSH = 3'd6;

  // microcode rom: when the condition holds, jump without action
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '0;
    unique case (pc)
      STEP_IDLE: begin
        w.cond = COND_NO_START;
        w.jump = STEP_IDLE;
        w.next = STEP_INIT;
      end
      STEP_INIT: begin
        w.cond           = COND_NEVER;
        w.next           = STEP_POPRQ;
        w.ctrl.push      = 1'b1;
        w.ctrl.push_zero = 1'b1;
        w.ctrl.visit     = VISIT_INIT;
      end
      STEP_POPRQ: begin
        w.cond     = COND_SP_EMPTY;
        w.jump     = STEP_FLUSH;
        w.next     = STEP_POPUS;
        w.ctrl.pop = 1'b1;
      end
      STEP_POPUS: begin
        w.cond                = COND_NEVER;
        w.next                = STEP_SCAN;
        w.ctrl.cur_from_stack = 1'b1;
      end
      STEP_SCAN: begin
        w.cond              = COND_NO_NBR;
        w.jump              = STEP_POPRQ;
        w.next              = STEP_PUSH;
        w.ctrl.push         = 1'b1;
        w.ctrl.cur_from_nbr = 1'b1;
        w.ctrl.visit        = VISIT_SET;
        w.ctrl.emit         = 1'b1;
      end
      STEP_PUSH: begin
        w.cond      = COND_NEVER;
        w.next      = STEP_SCAN;
        w.ctrl.push = 1'b1;
      end
      STEP_FLUSH: begin
        w.cond           = COND_NEVER;
        w.next           = STEP_IDLE;
        w.ctrl.visit     = VISIT_CLEAR;
        w.ctrl.emit      = 1'b1;
        w.ctrl.emit_last = 1'b1;
      end
      default: begin
        w.cond = COND_NEVER;
        w.next = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  logic [PC_W-1:0] pc_q, pc_d;
  uword_t          uw;
  logic            taken;
  logic            stall;

  assign uw = ucode(pc_q);

  always_comb begin
    unique case (uw.cond)
      COND_NEVER:    taken = 1'b0;
      COND_NO_START: taken = !start_i;
      COND_SP_EMPTY: taken = stat_i.sp_empty;
      COND_NO_NBR:   taken = !stat_i.nbr_found;
      default:       taken = 1'b0;
    endcase
  end

  // an emitting step waits for the output register
  assign stall = !taken && uw.ctrl.emit && !stat_i.out_free;

  always_comb begin
    if (taken) begin
      pc_d = uw.jump;
    end else if (stall) begin
      pc_d = pc_q;
    end else begin
      pc_d = uw.next;
    end
  end

  assign ctrl_o = (taken || stall) ? '0 : uw.ctrl;
  assign idle_o = (pc_q == STEP_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// File: design/dfsw_datapath.sv
module dfsw_datapath #(
  parameter int unsigned MAX_VERTICES = dfsw_pkg::DEF_MAX_VERTICES,
  parameter int unsigned STACK_DEPTH  = dfsw_pkg::DEF_STACK_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_accept_i,
  input  logic [dfsw_pkg::OP_W-1:0]      op_i,
  input  logic [dfsw_pkg::VW-1:0]        edge_from_i,
  input  logic [dfsw_pkg::VW-1:0]        edge_to_i,
  input  logic [dfsw_pkg::VCOUNT_W-1:0]  vertex_count_i,
  input  dfsw_pkg::ctrl_t                ctrl_i,
  output dfsw_pkg::stat_t                stat_o,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [dfsw_pkg::VW-1:0]        out_vertex_o,
  output logic                           out_last_o
);
  import dfsw_pkg::*;

  // vertices that can ever hold an edge and be scanned
  localparam int unsigned NV = (MAX_VERTICES < SCAN_MAX) ? MAX_VERTICES : SCAN_MAX;
  localparam int unsigned RW = $clog2(NV);
  localparam int unsigned SW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IW = $clog2(STACK_DEPTH);

  logic [NV-1:0] rows_q [NV];
  logic [NV-1:0] visited_q, visited_d;
  logic [VW-1:0] cur_q, cur_d;
  logic [VW-1:0] pend_q, pend_d;
  logic [VW-1:0] rd_q;
  logic [SW-1:0] sp_q, sp_d;
  logic [SW-1:0] sp_dec;
  logic [VW-1:0] stack_mem [STACK_DEPTH];
  logic          out_valid_q, out_valid_d;
  logic [VW-1:0] out_vertex_q;
  logic          out_last_q;

  logic [NV-1:0] cur_row;
  logic [NV-1:0] cand;
  logic [VW-1:0] nbr;
  logic          push_ok;
  logic [VW-1:0] push_data;
  logic          edge_ok;

  // neighbour search: lowest unvisited neighbour inside the scan limit
  assign cur_row = rows_q[cur_q[RW-1:0]];

  always_comb begin
    for (int i = 0; i < NV; i++) begin
      cand[i] = cur_row[i] && !visited_q[i] && (VCOUNT_W'(i) < vertex_count_i);
    end
  end

  always_comb begin
    nbr = '0;
    for (int i = NV - 1; i >= 0; i--) begin
      if (cand[i]) begin
        nbr = VW'(i);
      end
    end
  end

  assign stat_o.nbr_found = |cand;
  assign stat_o.sp_empty  = (sp_q == '0);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  // adjacency rows
  assign edge_ok = (32'(edge_from_i) < NV) && (32'(edge_to_i) < NV);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NV; r++) begin
        rows_q[r] <= '0;
      end
    end else if (in_accept_i && (op_i == OP_CLEAR)) begin
      for (int r = 0; r < NV; r++) begin
        rows_q[r] <= '0;
      end
    end else if (in_accept_i && (op_i == OP_SET_EDGE) && edge_ok) begin
      rows_q[edge_from_i[RW-1:0]][edge_to_i[RW-1:0]] <= 1'b1;
    end
  end

  // visited marks and walk registers
  always_comb begin
    visited_d = visited_q;
    pend_d    = pend_q;
    unique case (ctrl_i.visit)
      VISIT_NONE:  visited_d = visited_q;
      VISIT_INIT: begin
        visited_d = NV'(1);
        pend_d    = '0;
      end
      VISIT_SET: begin
        visited_d = visited_q | (NV'(1) << nbr);
        pend_d    = nbr;
      end
      VISIT_CLEAR: visited_d = '0;
      default:     visited_d = visited_q;
    endcase
  end

  always_comb begin
    cur_d = cur_q;
    if (ctrl_i.cur_from_stack) begin
      cur_d = rd_q;
    end else if (ctrl_i.cur_from_nbr) begin
      cur_d = nbr;
    end
  end

  // stack pointer; a push onto a full stack is dropped
  assign push_ok   = ctrl_i.push && (sp_q != SW'(STACK_DEPTH));
  assign push_data = ctrl_i.push_zero ? '0 : cur_q;
  assign sp_dec    = sp_q - 1'b1;

  always_comb begin
    sp_d = sp_q;
    if (push_ok) begin
      sp_d = sp_q + 1'b1;
    end else if (ctrl_i.pop) begin
      sp_d = sp_dec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      stack_mem[sp_q[IW-1:0]] <= push_data;
    end
    if (ctrl_i.pop) begin
      rd_q <= stack_mem[sp_dec[IW-1:0]];
    end
  end

  // output register
  always_comb begin
    if (ctrl_i.emit) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && !out_ready_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      out_vertex_q <= pend_q;
      out_last_q   <= ctrl_i.emit_last;
    end
    pend_q <= pend_d;
    cur_q  <= cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q   <= '0;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      visited_q   <= visited_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_vertex_o = out_vertex_q;
  assign out_last_o   = out_last_q;

`ifndef SYNTH
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(sp_q) <= STACK_DEPTH)
    else $error("stack pointer past stack depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop |-> (sp_q != '0))
    else $error("pop from empty stack");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result word overwritten before taken");

  a_root_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.visit == VISIT_SET) |-> visited_q[0])
    else $error("neighbour visited before root");
`endif

endmodule

// File: design/dfs_adjacency_matrix_walk_unit.sv
// depth-first walk over a directed adjacency bit matrix of up to eight scanned
// vertices. input words carry op in tuser and edge_from/edge_to in tdata: set edge
// and clear-all take one word per cycle while no walk runs; walk starts at vertex
// 0, always takes the lowest unvisited neighbour, and streams the visited vertices
// in discovery order on the master side, tlast on the final one. the walk is run
// by a seven-step microcode program over a datapath with one explicit stack in a
// single-port memory; each pop costs a registered memory read. the slave side's
// tready stays low from the walk word until the final vertex enters the output
// register, also while the master side stalls. results are held one word behind
// so tlast can be set on the final vertex. vertex_count (cfg port, reset 8)
// limits the neighbour scan; a count of zero still yields vertex 0 alone. write
// it only while idle.
module dfs_adjacency_matrix_walk_unit #(
  parameter int unsigned MAX_VERTICES = dfsw_pkg::DEF_MAX_VERTICES,
  parameter int unsigned STACK_DEPTH  = dfsw_pkg::DEF_STACK_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input words
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [2:0] edge_from, [5:3] edge_to, [7:6] zero
  input  logic [1:0] s_axis_tuser,  // [1:0] op
  // result words
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [2:0] vertex, [7:3] zero
  output logic       m_axis_tlast,
  // vertex_count register
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] cfg_data_i
);
  import dfsw_pkg::*;

  logic [VCOUNT_W-1:0] vertex_count_q;
  logic                in_accept;
  logic                start;
  logic                idle;
  ctrl_t               ctrl;
  stat_t               stat;
  logic [VW-1:0]       out_vertex;

  // the register port never stalls
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= VCOUNT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      vertex_count_q <= cfg_data_i;
    end
  end

  // words are taken only while the sequencer sits at its idle step
  assign s_axis_tready = idle;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign start         = in_accept && (s_axis_tuser == OP_WALK);

  dfsw_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .idle_o  (idle)
  );

  dfsw_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .STACK_DEPTH  (STACK_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_accept_i    (in_accept),
    .op_i           (s_axis_tuser),
    .edge_from_i    (s_axis_tdata[2:0]),
    .edge_to_i      (s_axis_tdata[5:3]),
    .vertex_count_i (vertex_count_q),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_vertex_o   (out_vertex),
    .out_last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, out_vertex};

endmodule
